>>> hw/rtl/qpd_pkg.sv
// Shared types, character codes and hex helpers for the quoted-printable decoder.
`timescale 1ns / 1ps

package qpd_pkg;

    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    // Result queue depth and pointer width (pointer wraps naturally).
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned PTR_W       = 2;
    localparam int unsigned CNT_W       = 3;
    // Most results one input transaction can release.
    localparam int unsigned MAX_RES     = 3;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_EQ      = 2'd1,
        PH_EQ_CR   = 2'd2,
        PH_EQ_HEX  = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       run_last;
        logic       body_end;
        logic       bad_escape;
    } t_out;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] held;
        logic       err;
    } t_state;

    typedef struct packed {
        logic [1:0]           count;
        t_out [MAX_RES-1:0]   item;
        t_state               next;
    } t_step;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= 8'h30 && c <= 8'h39) ||
                 (c >= 8'h41 && c <= 8'h46) ||
                 (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end
        hex_val = v[3:0];
    endfunction

endpackage

>>> hw/rtl/qpd_step.sv
// Combinational decode of one byte: next escape state and up to three results.
`timescale 1ns / 1ps

module qpd_step (
    input  qpd_pkg::t_state i_state,
    input  qpd_pkg::t_in    i_in,
    input  logic            i_strict_mode,
    output qpd_pkg::t_step  o_step
);

    always_comb begin
        logic [7:0]       c;
        logic             c_eq;
        logic             c_lf;
        logic             c_cr;
        logic             c_hex;
        logic             bad;
        logic             do_plain;
        logic             err_after;
        logic [1:0]       n;
        qpd_pkg::t_phase  np;
        logic [7:0]       nh;
        qpd_pkg::t_out    item [qpd_pkg::MAX_RES];

        c        = i_in.in_byte;
        c_eq     = (c == qpd_pkg::CH_EQ);
        c_lf     = (c == qpd_pkg::CH_LF);
        c_cr     = (c == qpd_pkg::CH_CR);
        c_hex    = qpd_pkg::is_hex(c);
        bad      = 1'b0;
        do_plain = 1'b0;
        n        = 2'd0;
        np       = i_state.phase;
        nh       = i_state.held;
        for (int k = 0; k < qpd_pkg::MAX_RES; k++) begin
            item[k] = '0;
        end

        case (i_state.phase)
            qpd_pkg::PH_IDLE: begin
                do_plain = 1'b1;
            end
            qpd_pkg::PH_EQ: begin
                if (c_lf) begin
                    np = qpd_pkg::PH_IDLE;
                end else if (c_cr) begin
                    nh = c;
                    np = qpd_pkg::PH_EQ_CR;
                end else if (c_hex) begin
                    nh = c;
                    np = qpd_pkg::PH_EQ_HEX;
                end else begin
                    bad = 1'b1;
                    item[n].out_byte  = qpd_pkg::CH_EQ;
                    item[n].out_valid = 1'b1;
                    n = n + 2'd1;
                    np = qpd_pkg::PH_IDLE;
                    do_plain = 1'b1;
                end
            end
            qpd_pkg::PH_EQ_CR: begin
                np = qpd_pkg::PH_IDLE;
                if (!c_lf) begin
                    bad = 1'b1;
                    item[n].out_byte  = qpd_pkg::CH_EQ;
                    item[n].out_valid = 1'b1;
                    n = n + 2'd1;
                    item[n].out_byte  = i_state.held;
                    item[n].out_valid = 1'b1;
                    n = n + 2'd1;
                    do_plain = 1'b1;
                end
            end
            qpd_pkg::PH_EQ_HEX: begin
                np = qpd_pkg::PH_IDLE;
                if (c_hex) begin
                    item[n].out_byte  = {qpd_pkg::hex_val(i_state.held), qpd_pkg::hex_val(c)};
                    item[n].out_valid = 1'b1;
                    n = n + 2'd1;
                end else begin
                    bad = 1'b1;
                    item[n].out_byte  = qpd_pkg::CH_EQ;
                    item[n].out_valid = 1'b1;
                    n = n + 2'd1;
                    item[n].out_byte  = i_state.held;
                    item[n].out_valid = 1'b1;
                    n = n + 2'd1;
                    do_plain = 1'b1;
                end
            end
            default: begin
                np = qpd_pkg::PH_IDLE;
            end
        endcase

        // Byte seen with no escape pending: '=' opens one, anything else passes.
        if (do_plain) begin
            if (c_eq) begin
                np = qpd_pkg::PH_EQ;
            end else begin
                item[n].out_byte  = c;
                item[n].out_valid = 1'b1;
                n = n + 2'd1;
            end
        end

        // End of body flushes a pending escape as literals.
        if (i_in.in_last) begin
            if (np != qpd_pkg::PH_IDLE) begin
                bad = 1'b1;
                item[n].out_byte  = qpd_pkg::CH_EQ;
                item[n].out_valid = 1'b1;
                n = n + 2'd1;
                if (np == qpd_pkg::PH_EQ_CR || np == qpd_pkg::PH_EQ_HEX) begin
                    item[n].out_byte  = nh;
                    item[n].out_valid = 1'b1;
                    n = n + 2'd1;
                end
                np = qpd_pkg::PH_IDLE;
            end
            if (n == 2'd0) begin
                // Empty marker result closes the body.
                n = 2'd1;
            end
        end

        err_after = i_state.err | (bad & i_strict_mode);

        for (int k = 0; k < qpd_pkg::MAX_RES; k++) begin
            item[k].bad_escape = err_after;
            item[k].run_last   = (n == 2'(k + 1));
            item[k].body_end   = (n == 2'(k + 1)) & i_in.in_last;
        end

        o_step.count      = n;
        o_step.next.phase = np;
        o_step.next.held  = nh;
        o_step.next.err   = i_in.in_last ? 1'b0 : err_after;
        for (int k = 0; k < qpd_pkg::MAX_RES; k++) begin
            o_step.item[k] = item[k];
        end
    end

endmodule

>>> hw/rtl/quoted_printable_stream_decoder.sv
// Top level of the streaming quoted-printable decoder with its result queue.
`timescale 1ns / 1ps

// Streaming quoted-printable decoder. Takes one encoded body byte per input
// transaction and decodes it in the same cycle; its up to three results are
// registered in a four-entry result queue and leave one per output
// transaction. The input is ready whenever the queue holds at most one
// result, so with a draining consumer the block sustains one byte per cycle
// (a soft break or the first half of an escape gives no result at all). The
// queue's single read port caps the output rate at one result per cycle: a
// failed escape releasing two or three results holds the input off while
// they drain. In strict mode a malformed escape sets bad_escape on that
// byte's results and every later result of the body; the flag clears after
// the body's final result is queued. The user writes strict mode through
// i_cfg_we/i_cfg_wdata only while idle; the block does not enforce this.

module quoted_printable_stream_decoder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // configuration
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata,
    // encoded byte input
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  qpd_pkg::t_in   i_in,
    // decoded result output
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output qpd_pkg::t_out  o_out
);

    logic                               r_strict_mode;
    qpd_pkg::t_state                    r_state;
    qpd_pkg::t_out                      r_queue [qpd_pkg::QUEUE_DEPTH];
    logic [qpd_pkg::PTR_W-1:0]          r_wr_ptr;
    logic [qpd_pkg::PTR_W-1:0]          r_rd_ptr;
    logic [qpd_pkg::CNT_W-1:0]          r_count;
    logic [qpd_pkg::CNT_W-1:0]          n_count;

    qpd_pkg::t_step                     step;
    logic                               in_xact;
    logic                               out_xact;
    logic [qpd_pkg::CNT_W-1:0]          push_cnt;

    // Decode logic sits between the input port and the queue registers.
    qpd_step u_step (
        .i_state       (r_state),
        .i_in          (i_in),
        .i_strict_mode (r_strict_mode),
        .o_step        (step)
    );

    // Room for a worst-case batch of results, judged from registered fill only.
    assign o_in_ready  = (r_count <= qpd_pkg::CNT_W'(qpd_pkg::QUEUE_DEPTH - qpd_pkg::MAX_RES));
    assign in_xact     = i_in_valid & o_in_ready;
    assign o_out_valid = (r_count != '0);
    assign out_xact    = o_out_valid & i_out_ready;
    assign o_out       = r_queue[r_rd_ptr];

    assign push_cnt = in_xact ? qpd_pkg::CNT_W'(step.count) : '0;
    assign n_count  = r_count + push_cnt - qpd_pkg::CNT_W'(out_xact);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_strict_mode <= i_cfg_wdata;
        end
    end

    // Escape state advances only on an accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase <= qpd_pkg::PH_IDLE;
            r_state.held  <= '0;
            r_state.err   <= 1'b0;
        end else if (in_xact) begin
            r_state <= step.next;
        end
    end

    // Queue payload: no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_xact) begin
            for (int k = 0; k < qpd_pkg::MAX_RES; k++) begin
                if (2'(k) < step.count) begin
                    r_queue[r_wr_ptr + qpd_pkg::PTR_W'(k)] <= step.item[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + push_cnt[qpd_pkg::PTR_W-1:0];
            r_rd_ptr <= r_rd_ptr + qpd_pkg::PTR_W'(out_xact);
            r_count  <= n_count;
        end
    end

    // Queue never overfills.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= qpd_pkg::CNT_W'(qpd_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    // A body's last byte always yields a result.
    a_last_yields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xact && i_in.in_last |-> step.count != 2'd0)
        else $error("end of body produced no result");

    // After a body ends, no escape is pending and the error flag is clear.
    a_body_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xact && i_in.in_last |=> r_state.phase == qpd_pkg::PH_IDLE && !r_state.err)
        else $error("state not clean after end of body");

    // Fill drops by one on a pop with no push.
    a_fill_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xact && !in_xact |=> r_count == $past(r_count) - 3'd1)
        else $error("fill count mismatch on pop");

endmodule

>>> tb/qpd_stream_checker.sv
// Checker for the quoted-printable decoder: tracks the channels, predicts results and compares them.
`timescale 1ns / 1ps

module qpd_stream_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  qpd_pkg::t_in    i_in,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  qpd_pkg::t_out   i_out,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_checked
);

    // predictor state
    logic            strict_q;
    qpd_pkg::t_phase phase_q;
    logic [7:0]      held_q;
    logic            err_q;

    qpd_pkg::t_out step_res[$];
    qpd_pkg::t_out decoded_q[$];
    int            fail_count = 0;
    int            checked_count = 0;

    // {is digit, nibble}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return {1'b1, c[3:0]};
        end
        if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
            return {1'b1, c[3:0] + 4'd9};
        end
        return 5'd0;
    endfunction

    task automatic emit(input logic [7:0] b, input logic v);
        qpd_pkg::t_out r;
        r           = '0;
        r.out_byte  = b;
        r.out_valid = v;
        step_res.push_back(r);
    endtask

    task automatic malformed();
        if (strict_q) begin
            err_q = 1'b1;
        end
    endtask

    task automatic take_plain(input logic [7:0] c);
        if (c == qpd_pkg::CH_EQ) begin
            phase_q = qpd_pkg::PH_EQ;
        end else begin
            emit(c, 1'b1);
        end
    endtask

    task automatic qp_decode_step(input qpd_pkg::t_in tx);
        logic [4:0] h;
        logic [4:0] hh;
        logic [7:0] c;
        c = tx.in_byte;
        h = hex_digit(c);
        step_res.delete();
        case (phase_q)
            qpd_pkg::PH_IDLE: begin
                take_plain(c);
            end
            qpd_pkg::PH_EQ: begin
                if (c == qpd_pkg::CH_LF) begin
                    phase_q = qpd_pkg::PH_IDLE;
                end else if (c == qpd_pkg::CH_CR) begin
                    held_q  = c;
                    phase_q = qpd_pkg::PH_EQ_CR;
                end else if (h[4]) begin
                    held_q  = c;
                    phase_q = qpd_pkg::PH_EQ_HEX;
                end else begin
                    malformed();
                    emit(qpd_pkg::CH_EQ, 1'b1);
                    phase_q = qpd_pkg::PH_IDLE;
                    take_plain(c);
                end
            end
            qpd_pkg::PH_EQ_CR: begin
                phase_q = qpd_pkg::PH_IDLE;
                if (c != qpd_pkg::CH_LF) begin
                    malformed();
                    emit(qpd_pkg::CH_EQ, 1'b1);
                    emit(held_q, 1'b1);
                    take_plain(c);
                end
            end
            default: begin
                phase_q = qpd_pkg::PH_IDLE;
                if (h[4]) begin
                    hh = hex_digit(held_q);
                    emit({hh[3:0], h[3:0]}, 1'b1);
                end else begin
                    malformed();
                    emit(qpd_pkg::CH_EQ, 1'b1);
                    emit(held_q, 1'b1);
                    take_plain(c);
                end
            end
        endcase

        // open escape at end of body is flushed as literals
        if (tx.in_last) begin
            if (phase_q != qpd_pkg::PH_IDLE) begin
                malformed();
                emit(qpd_pkg::CH_EQ, 1'b1);
                if (phase_q == qpd_pkg::PH_EQ_CR || phase_q == qpd_pkg::PH_EQ_HEX) begin
                    emit(held_q, 1'b1);
                end
                phase_q = qpd_pkg::PH_IDLE;
            end
            if (step_res.size() == 0) begin
                emit(8'h00, 1'b0);
            end
        end

        foreach (step_res[k]) begin
            step_res[k].bad_escape = err_q;
        end
        if (step_res.size() > 0) begin
            step_res[step_res.size()-1].run_last = 1'b1;
            step_res[step_res.size()-1].body_end = tx.in_last;
        end
        foreach (step_res[k]) begin
            decoded_q.push_back(step_res[k]);
        end
        if (tx.in_last) begin
            err_q = 1'b0;
        end
    endtask

    task automatic check_result(input qpd_pkg::t_out got);
        qpd_pkg::t_out exp_r;
        if (decoded_q.size() == 0) begin
            $error("unexpected result: out_byte %02h out_valid %0b", got.out_byte, got.out_valid);
            fail_count++;
            return;
        end
        exp_r = decoded_q.pop_front();
        checked_count++;
        if (got.out_byte !== exp_r.out_byte) begin
            $error("out_byte: expected %02h, got %02h", exp_r.out_byte, got.out_byte);
            fail_count++;
        end
        if (got.out_valid !== exp_r.out_valid) begin
            $error("out_valid: expected %0b, got %0b", exp_r.out_valid, got.out_valid);
            fail_count++;
        end
        if (got.run_last !== exp_r.run_last) begin
            $error("run_last: expected %0b, got %0b", exp_r.run_last, got.run_last);
            fail_count++;
        end
        if (got.body_end !== exp_r.body_end) begin
            $error("body_end: expected %0b, got %0b", exp_r.body_end, got.body_end);
            fail_count++;
        end
        if (got.bad_escape !== exp_r.bad_escape) begin
            $error("bad_escape: expected %0b, got %0b", exp_r.bad_escape, got.bad_escape);
            fail_count++;
        end
    endtask

    // output is compared before the input is predicted; a byte's results
    // can never leave on the edge that accepts it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            strict_q = 1'b0;
            phase_q  = qpd_pkg::PH_IDLE;
            held_q   = 8'h00;
            err_q    = 1'b0;
            decoded_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_result(i_out);
            end
            if (i_in_valid && i_in_ready) begin
                qp_decode_step(i_in);
            end
            if (i_cfg_we) begin
                strict_q = i_cfg_wdata;
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= decoded_q.size();
        o_checked    <= checked_count;
    end

endmodule

>>> tb/quoted_printable_stream_decoder_tb.sv
// Testbench top for the quoted-printable decoder: stimulus, consumer stalls and verdict.
`timescale 1ns / 1ps

module quoted_printable_stream_decoder_tb;

    // Generous bound: ~200 transactions, each with up to three results that may
    // each wait out a long consumer stall, plus the long hold and config gaps.
    localparam int CYCLE_LIMIT = 200000;
    // Results leave the block from a registered queue after their byte is taken.
    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_HOLD_CYCLES = 200;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_cfg_we;
    logic           i_cfg_wdata;
    logic           i_in_valid;
    logic           o_in_ready;
    qpd_pkg::t_in   i_in;
    logic           o_out_valid;
    logic           i_out_ready;
    qpd_pkg::t_out  o_out;

    int fail_count;
    int pending_count;
    int checked_count;

    int cycle_count = 0;
    int n_sent = 0;
    int n_bodies = 0;
    int n_cfg_writes = 0;
    int n_long_holds = 0;

    // idling knobs, flipped per phase; hold_request asks the consumer for
    // one long hold-off
    logic src_idle_on;
    logic sink_idle_on;
    logic hold_request = 1'b0;

    quoted_printable_stream_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    qpd_stream_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out        (o_out),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Gap length: mostly none or short, now and then a long one.
    function automatic int pick_gap(input logic enabled);
        int r;
        if (!enabled) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        if (nib < 4'd10) begin
            return 8'h30 + nib;
        end
        return (upper ? 8'h41 : 8'h61) + (nib - 4'd10);
    endfunction

    // Consumer: random stalls, plus one long hold-off on request. The hold
    // is counted here so the producer keeps offering bytes meanwhile and
    // the result queue fills up and throttles the input.
    initial begin : consumer
        int stall_left;
        int g;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                n_long_holds++;
                stall_left = LONG_HOLD_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 99) < 35) begin
                g = pick_gap(1'b1);
                stall_left = (g > 0) ? g - 1 : 0;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // One input transaction. Valid stays high from one byte to the next when
    // there is no gap, so it is never dropped and raised in the same step.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap(src_idle_on);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_in.in_byte    <= b;
        i_in.in_last    <= last;
        do @(posedge i_clk); while (!o_in_ready);
        n_sent++;
        if (last) begin
            n_bodies++;
        end
    endtask

    task automatic send_body(input logic [7:0] body[$]);
        foreach (body[k]) begin
            send_byte(body[k], k == body.size() - 1);
        end
    endtask

    // Wait for every predicted result to drain, let a pending escape (which
    // gives no result) settle, then write strict mode.
    task automatic write_strict(input logic v);
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        n_cfg_writes++;
    endtask

    // Random body: mostly well-formed text with escapes and soft breaks, some
    // noise bytes and broken escapes, occasionally cut off inside an escape.
    task automatic send_random_body();
        logic [7:0] body[$];
        logic [7:0] v;
        int         n_tok;
        int         sel;
        n_tok = $urandom_range(1, 8);
        repeat (n_tok) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                v = 8'($urandom_range(8'h20, 8'h7E));
                body.push_back(v == qpd_pkg::CH_EQ ? 8'h2E : v);
            end else if (sel < 45) begin
                body.push_back(8'($urandom_range(0, 255)));   // noise, any byte
            end else if (sel < 70) begin
                v = 8'($urandom_range(0, 255));
                body.push_back(qpd_pkg::CH_EQ);
                body.push_back(hex_char(v[7:4], 1'($urandom_range(0, 1))));
                body.push_back(hex_char(v[3:0], 1'($urandom_range(0, 1))));
            end else if (sel < 80) begin
                body.push_back(qpd_pkg::CH_EQ);
                if ($urandom_range(0, 1)) begin
                    body.push_back(qpd_pkg::CH_CR);
                end
                body.push_back(qpd_pkg::CH_LF);
            end else if (sel < 88) begin
                // '=' then something that is usually not an escape
                body.push_back(qpd_pkg::CH_EQ);
                body.push_back($urandom_range(0, 3) == 0 ? qpd_pkg::CH_EQ
                                                         : 8'($urandom_range(0, 255)));
            end else if (sel < 94) begin
                body.push_back(qpd_pkg::CH_EQ);
                body.push_back(hex_char(4'($urandom_range(0, 15)),
                                        1'($urandom_range(0, 1))));
                body.push_back(8'($urandom_range(0, 255)));
            end else begin
                body.push_back(qpd_pkg::CH_EQ);
                body.push_back(qpd_pkg::CH_CR);
                body.push_back(8'($urandom_range(0, 255)));
            end
        end
        // truncated escape at end of body
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            body.push_back(qpd_pkg::CH_EQ);
        end else if (sel == 1) begin
            body.push_back(qpd_pkg::CH_EQ);
            body.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
        end else if (sel == 2) begin
            body.push_back(qpd_pkg::CH_EQ);
            body.push_back(qpd_pkg::CH_CR);
        end
        send_body(body);
    endtask

    task automatic run_random(input int count);
        int start;
        start = n_sent;
        while (n_sent - start < count) begin
            send_random_body();
        end
    endtask

    initial begin : stimulus
        logic [7:0] body[$];
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = 1'b0;
        i_in_valid   = 1'b0;
        i_in         = '0;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed, lenient mode ----
        write_strict(1'b0);
        // byte extremes, a digit-only and a lower case escape, both soft breaks; the
        // body ends on a soft break, so it closes with an empty result
        body = '{8'h00, 8'hFF, qpd_pkg::CH_EQ, "4", "1", qpd_pkg::CH_EQ, "a", "9",
                 qpd_pkg::CH_EQ, qpd_pkg::CH_LF, qpd_pkg::CH_EQ, qpd_pkg::CH_CR,
                 qpd_pkg::CH_LF};
        send_body(body);

        // ---- directed, strict mode ----
        write_strict(1'b1);
        // double equals, CR not followed by LF, hex then non-hex, and an
        // escape still open when the body ends
        body = '{qpd_pkg::CH_EQ, qpd_pkg::CH_EQ, "3", "D", qpd_pkg::CH_EQ, qpd_pkg::CH_CR,
                 "X", qpd_pkg::CH_EQ, "4", "Z", qpd_pkg::CH_EQ};
        send_body(body);

        // ---- random, lenient, idling on both sides ----
        write_strict(1'b0);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        run_random(35);

        // ---- random, strict, back-to-back traffic ----
        write_strict(1'b1);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        run_random(30);

        // Strict mode flipped while an escape is open: the bad second digit
        // must be judged under the new setting.
        send_byte("x", 1'b0);
        send_byte(qpd_pkg::CH_EQ, 1'b0);
        write_strict(1'b0);
        send_byte("4", 1'b0);
        send_byte("Q", 1'b1);
        send_byte(qpd_pkg::CH_EQ, 1'b0);
        write_strict(1'b1);
        send_byte("G", 1'b1);

        // ---- random, strict, consumer holds off while the producer streams ----
        sink_idle_on = 1'b1;
        hold_request = 1'b1;
        run_random(35);

        // ---- random, lenient, idling on both sides ----
        write_strict(1'b0);
        src_idle_on = 1'b1;
        run_random(35);

        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes in %0d bodies; %0d results checked.",
                 n_sent, n_bodies, checked_count);
        $display("Strict mode written %0d times; %0d long consumer hold-off(s).",
                 n_cfg_writes, n_long_holds);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
